@@ hw/rtl/i2cee_pkg.sv @@
`default_nettype none
package i2cee_pkg;

    // buffer and bus timing
    localparam int BUFFER_DEPTH    = 256;
    localparam int BUF_AW          = $clog2(BUFFER_DEPTH);
    localparam int TICKS_PER_DELAY = 1;
    localparam int PRE_W           = $clog2(TICKS_PER_DELAY) + 1;

    // input modes
    localparam logic [2:0] MODE_TICK  = 3'd0;
    localparam logic [2:0] MODE_LOAD  = 3'd1;
    localparam logic [2:0] MODE_READ  = 3'd2;
    localparam logic [2:0] MODE_WRITE = 3'd3;
    localparam logic [2:0] MODE_FILL  = 3'd4;

    // operation kinds
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_FILL  = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NACK     = 2'd1;
    localparam logic [1:0] ST_MISMATCH = 2'd2;
    localparam logic [1:0] ST_BAD      = 2'd3;

    // config register indexes
    localparam logic [2:0] CFG_BIT_ORDER  = 3'd0;
    localparam logic [2:0] CFG_TWO_BYTE   = 3'd1;
    localparam logic [2:0] CFG_PAGE_MASK  = 3'd2;
    localparam logic [2:0] CFG_WRITE_WAIT = 3'd3;
    localparam logic [2:0] CFG_FILL_WAIT  = 3'd4;

    // send step results
    localparam logic [1:0] SEND_RUN  = 2'd0;
    localparam logic [1:0] SEND_ACK  = 2'd1;
    localparam logic [1:0] SEND_NACK = 2'd2;

endpackage
`default_nettype wire

@@ hw/rtl/i2c_eeprom_page_write_verify_master.sv @@
// an accepted word's result word is registered in the output register in the next cycle
// throughput: one word per cycle while the output is not stalled; each word is one bus delay tick or one command
// the pin sequencer advances one step per tick word; write-cycle waits count tick words
// reset: idle, scl/sda_oe/sda_out high, config at defaults; the page buffer is not cleared
`default_nettype none
module i2c_eeprom_page_write_verify_master
    import i2cee_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [23:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  mode,
    input  wire logic        sda_in,
    input  wire logic [7:0]  data_byte,
    input  wire logic [15:0] start_address,
    input  wire logic [15:0] byte_count,
    input  wire logic [7:0]  device_address,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             scl,
    output logic             sda_oe,
    output logic             sda_out,
    output logic [7:0]       read_byte,
    output logic             read_valid,
    output logic             busy_res,
    output logic             done_res,
    output logic [1:0]       status
);

    // phase codes
    localparam logic [3:0] PH_IDLE      = 4'd0;
    localparam logic [3:0] PH_AD_START  = 4'd1;
    localparam logic [3:0] PH_AD_CTRL   = 4'd2;
    localparam logic [3:0] PH_AD_HI     = 4'd3;
    localparam logic [3:0] PH_AD_LO     = 4'd4;
    localparam logic [3:0] PH_WR_DATA   = 4'd5;
    localparam logic [3:0] PH_PAGE_STOP = 4'd6;
    localparam logic [3:0] PH_WAIT      = 4'd7;
    localparam logic [3:0] PH_RD_START  = 4'd8;
    localparam logic [3:0] PH_RD_CTRL   = 4'd9;
    localparam logic [3:0] PH_RD_BYTE   = 4'd10;
    localparam logic [3:0] PH_RD_LAST   = 4'd11;
    localparam logic [3:0] PH_END_STOP  = 4'd12;

    // config registers
    logic        msb_reg, two_byte_reg;
    logic [7:0]  page_mask_reg;
    logic [23:0] write_wait_reg, fill_wait_reg;

    // sequencer state
    logic [3:0]       ph_reg, ph_next;
    logic [2:0]       ts_reg, ts_next;
    logic [3:0]       bi_reg, bi_next;
    logic [7:0]       sb_reg, sb_next;
    logic [15:0]      ca_reg, ca_next;
    logic [15:0]      bd_reg, bd_next;
    logic [23:0]      wc_reg, wc_next;
    logic [1:0]       ec_reg, ec_next;
    logic [PRE_W-1:0] ps_reg, ps_next;
    logic [1:0]       op_reg, op_next;
    logic [15:0]      rc_reg, rc_next;
    logic [15:0]      ba_reg, ba_next;
    logic [7:0]       da_reg, da_next;
    logic [7:0]       fv_reg, fv_next;
    logic             wr_reg, wr_next;
    logic             scl_reg, scl_next;
    logic             oe_reg, oe_next;
    logic             sdo_reg, sdo_next;

    // result word
    logic       ov_reg;
    logic [7:0] rb_reg, rb_next;
    logic       rv_reg, rv_next;
    logic       busy_reg;
    logic       done_reg, done_next;
    logic [1:0] st_reg, st_next;

    // page buffer
    logic [7:0]        buf_mem [BUFFER_DEPTH];
    logic [7:0]        exp_q;
    logic [BUF_AW-1:0] rd_addr;
    logic              accept;
    logic              load_en;
    logic [7:0]        exp_byte;
    logic [7:0]        ctrl_byte;

    assign in_stall = ov_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign load_en  = accept && (ph_reg == PH_IDLE) && (mode == MODE_LOAD)
                      && ({1'b0, start_address} < 17'(BUFFER_DEPTH));
    assign rd_addr  = accept ? bd_next[BUF_AW-1:0] : bd_reg[BUF_AW-1:0];
    assign exp_byte = (op_reg == OP_FILL) ? fv_reg : exp_q;
    assign ctrl_byte = two_byte_reg ? da_reg : (da_reg | {4'b0, ca_reg[10:8], 1'b0});

    // buffer write on load, registered read of the entry at bytes_done
    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            buf_mem[start_address[BUF_AW-1:0]] <= data_byte;
        end
        exp_q <= buf_mem[rd_addr];
    end

    // next state for one accepted word
    always_comb
    begin
        logic [1:0] sres;
        logic       rdone;
        logic       sdone;
        logic       run;
        logic       ack;
        logic [7:0] src;
        logic [23:0] wt;

        ph_next = ph_reg; ts_next = ts_reg; bi_next = bi_reg; sb_next = sb_reg;
        ca_next = ca_reg; bd_next = bd_reg; wc_next = wc_reg; ec_next = ec_reg;
        ps_next = ps_reg; op_next = op_reg; rc_next = rc_reg; ba_next = ba_reg;
        da_next = da_reg; fv_next = fv_reg; wr_next = wr_reg;
        scl_next = scl_reg; oe_next = oe_reg; sdo_next = sdo_reg;
        rb_next = 8'd0; rv_next = 1'b0; done_next = 1'b0; st_next = ST_OK;
        sres = SEND_RUN; rdone = 1'b0; sdone = 1'b0; run = 1'b0;
        ack = (ph_reg == PH_RD_BYTE);
        src = sb_reg;
        wt = 24'd0;

        if (ph_reg == PH_IDLE)
        begin
            if (mode == MODE_READ || mode == MODE_WRITE || mode == MODE_FILL)
            begin
                op_next = (mode == MODE_READ) ? OP_READ :
                          (mode == MODE_WRITE) ? OP_WRITE : OP_FILL;
                if (byte_count == 16'd0 || (mode == MODE_WRITE &&
                    {1'b0, byte_count} > 17'(BUFFER_DEPTH)))
                begin
                    done_next = 1'b1;
                    st_next = ST_BAD;
                end
                else
                begin
                    rc_next = byte_count; ba_next = start_address;
                    da_next = device_address; fv_next = data_byte;
                    ca_next = start_address; bd_next = 16'd0; wc_next = 24'd0;
                    ec_next = ST_OK; ps_next = '0; sb_next = 8'd0;
                    wr_next = (mode != MODE_READ);
                    ph_next = PH_AD_START; ts_next = 3'd0; bi_next = 4'd0;
                end
            end
        end
        else if (mode == MODE_TICK)
        begin
            if (ps_reg != '0)
            begin
                ps_next = ps_reg + 1'b1;
                if (ps_next >= PRE_W'(TICKS_PER_DELAY))
                begin
                    ps_next = '0;
                end
            end
            else if (ph_reg == PH_WAIT)
            begin
                if (wc_reg <= 24'd1)
                begin
                    wc_next = 24'd0;
                    if (bd_reg == rc_reg)
                    begin
                        wr_next = 1'b0;
                        ca_next = ba_reg;
                    end
                    ph_next = PH_AD_START; ts_next = 3'd0; bi_next = 4'd0;
                end
                else
                begin
                    wc_next = wc_reg - 24'd1;
                end
            end
            else
            begin
                run = 1'b1;
            end
        end

        if (run)
        begin
            // start and stop conditions
            if (ph_reg == PH_AD_START || ph_reg == PH_RD_START)
            begin
                unique case (ts_reg)
                    3'd0:
                    begin
                        if (ph_reg == PH_RD_START) scl_next = 1'b0;
                        oe_next = 1'b1; sdo_next = 1'b1; ts_next = ts_reg + 3'd1;
                    end
                    3'd1: begin scl_next = 1'b1; ts_next = ts_reg + 3'd1; end
                    3'd2: begin sdo_next = 1'b0; ts_next = ts_reg + 3'd1; end
                    default: begin scl_next = 1'b0; ts_next = 3'd0; sdone = 1'b1; end
                endcase
            end
            if (ph_reg == PH_PAGE_STOP || ph_reg == PH_END_STOP)
            begin
                unique case (ts_reg)
                    3'd0:
                    begin
                        oe_next = 1'b1; scl_next = 1'b0; ts_next = ts_reg + 3'd1;
                    end
                    3'd1: begin sdo_next = 1'b0; ts_next = ts_reg + 3'd1; end
                    3'd2: begin scl_next = 1'b1; ts_next = ts_reg + 3'd1; end
                    default: begin sdo_next = 1'b1; ts_next = 3'd0; sdone = 1'b1; end
                endcase
            end

            // byte send with acknowledge sample
            if (ph_reg == PH_AD_CTRL || ph_reg == PH_AD_HI || ph_reg == PH_AD_LO
                || ph_reg == PH_WR_DATA || ph_reg == PH_RD_CTRL)
            begin
                if (bi_reg == 4'd0)
                begin
                    scl_next = 1'b0; bi_next = 4'd1; ts_next = 3'd0;
                end
                else if (bi_reg <= 4'd8)
                begin
                    unique case (ts_reg)
                        3'd0:
                        begin
                            oe_next = 1'b1;
                            if (ph_reg == PH_WR_DATA && bi_reg == 4'd1) src = exp_byte;
                            sdo_next = msb_reg ? src[7] : src[0];
                            sb_next = msb_reg ? {src[6:0], 1'b0} : {1'b0, src[7:1]};
                        end
                        3'd1: scl_next = 1'b1;
                        3'd2: scl_next = scl_reg;
                        default: scl_next = 1'b0;
                    endcase
                    if (ts_reg >= 3'd3)
                    begin
                        ts_next = 3'd0; bi_next = bi_reg + 4'd1;
                    end
                    else
                    begin
                        ts_next = ts_reg + 3'd1;
                    end
                end
                else if (ts_reg == 3'd0)
                begin
                    oe_next = 1'b0; ts_next = 3'd1;
                end
                else
                begin
                    scl_next = 1'b1; ts_next = 3'd0; bi_next = 4'd0;
                    sres = sda_in ? SEND_NACK : SEND_ACK;
                end
            end

            // byte receive with optional acknowledge
            if (ph_reg == PH_RD_BYTE || ph_reg == PH_RD_LAST)
            begin
                if (bi_reg == 4'd0)
                begin
                    oe_next = 1'b0; scl_next = 1'b0; sb_next = 8'd0;
                    bi_next = 4'd1; ts_next = 3'd0;
                end
                else if (bi_reg <= 4'd8)
                begin
                    if (ts_reg == 3'd1)
                    begin
                        scl_next = 1'b1;
                        sb_next = msb_reg ? {sb_reg[6:0], sda_in} : {sda_in, sb_reg[7:1]};
                    end
                    else if (ts_reg >= 3'd3)
                    begin
                        scl_next = 1'b0;
                    end
                    if (ts_reg >= 3'd3)
                    begin
                        ts_next = 3'd0;
                        bi_next = bi_reg + 4'd1;
                        if (bi_next == 4'd9 && !ack)
                        begin
                            bi_next = 4'd0; rdone = 1'b1;
                        end
                    end
                    else
                    begin
                        ts_next = ts_reg + 3'd1;
                    end
                end
                else if (ts_reg == 3'd0)
                begin
                    oe_next = 1'b1; sdo_next = 1'b0; ts_next = 3'd1;
                end
                else if (ts_reg == 3'd1)
                begin
                    scl_next = 1'b1; ts_next = 3'd2;
                end
                else
                begin
                    ts_next = 3'd0; bi_next = 4'd0; rdone = 1'b1;
                end
            end

            // phase transitions
            unique case (ph_reg)
                PH_AD_START:
                begin
                    if (sdone)
                    begin
                        ph_next = PH_AD_CTRL; ts_next = 3'd0; bi_next = 4'd0;
                        sb_next = ctrl_byte;
                    end
                end
                PH_RD_START:
                begin
                    if (sdone)
                    begin
                        ph_next = PH_RD_CTRL; ts_next = 3'd0; bi_next = 4'd0;
                        sb_next = ctrl_byte | 8'h01;
                    end
                end
                PH_AD_CTRL, PH_AD_HI, PH_AD_LO, PH_WR_DATA, PH_RD_CTRL:
                begin
                    if (sres == SEND_NACK)
                    begin
                        ec_next = ST_NACK;
                        ph_next = PH_END_STOP; ts_next = 3'd0; bi_next = 4'd0;
                    end
                    else if (sres == SEND_ACK)
                    begin
                        ts_next = 3'd0; bi_next = 4'd0;
                        if (ph_reg == PH_AD_CTRL && two_byte_reg)
                        begin
                            ph_next = PH_AD_HI; sb_next = ca_reg[15:8];
                        end
                        else if (ph_reg == PH_AD_CTRL || ph_reg == PH_AD_HI)
                        begin
                            ph_next = PH_AD_LO; sb_next = ca_reg[7:0];
                        end
                        else if (ph_reg == PH_AD_LO)
                        begin
                            ph_next = wr_reg ? PH_WR_DATA : PH_RD_START;
                        end
                        else if (ph_reg == PH_WR_DATA)
                        begin
                            ca_next = ca_reg + 16'd1;
                            bd_next = bd_reg + 16'd1;
                            if ((ca_next[7:0] & page_mask_reg) == 8'd0 || bd_next == rc_reg)
                            begin
                                ph_next = PH_PAGE_STOP;
                            end
                        end
                        else
                        begin
                            bd_next = 16'd0;
                            ph_next = (rc_reg > 16'd1) ? PH_RD_BYTE : PH_RD_LAST;
                        end
                    end
                end
                PH_PAGE_STOP:
                begin
                    if (sdone)
                    begin
                        wt = (op_reg == OP_FILL) ? fill_wait_reg : write_wait_reg;
                        ts_next = 3'd0; bi_next = 4'd0;
                        if (wt == 24'd0)
                        begin
                            if (bd_reg == rc_reg)
                            begin
                                wr_next = 1'b0; ca_next = ba_reg;
                            end
                            ph_next = PH_AD_START;
                        end
                        else
                        begin
                            ph_next = PH_WAIT; wc_next = wt;
                        end
                    end
                end
                PH_RD_BYTE:
                begin
                    if (rdone)
                    begin
                        if (op_reg != OP_READ && sb_next != exp_byte)
                        begin
                            ec_next = ST_MISMATCH;
                            ph_next = PH_RD_LAST; ts_next = 3'd0; bi_next = 4'd0;
                        end
                        else
                        begin
                            if (op_reg == OP_READ)
                            begin
                                rb_next = sb_next; rv_next = 1'b1;
                            end
                            bd_next = bd_reg + 16'd1;
                            if (bd_next >= rc_reg - 16'd1)
                            begin
                                ph_next = PH_RD_LAST; ts_next = 3'd0; bi_next = 4'd0;
                            end
                        end
                    end
                end
                PH_RD_LAST:
                begin
                    if (rdone)
                    begin
                        if (op_reg == OP_READ)
                        begin
                            rb_next = sb_next; rv_next = 1'b1;
                        end
                        else if (sb_next != exp_byte)
                        begin
                            ec_next = ST_MISMATCH;
                        end
                        ph_next = PH_END_STOP; ts_next = 3'd0; bi_next = 4'd0;
                    end
                end
                PH_END_STOP:
                begin
                    if (sdone)
                    begin
                        ph_next = PH_IDLE; ts_next = 3'd0; bi_next = 4'd0;
                        done_next = 1'b1;
                    end
                end
                default:
                begin
                    ph_next = PH_IDLE; ts_next = 3'd0; bi_next = 4'd0;
                end
            endcase

            // delay prescaler and status on completion
            if (done_next)
            begin
                ps_next = '0;
                st_next = ec_next;
            end
            else
            begin
                ps_next = PRE_W'(1);
                if (ps_next >= PRE_W'(TICKS_PER_DELAY))
                begin
                    ps_next = '0;
                end
            end
        end
    end

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            msb_reg        <= 1'b1;
            two_byte_reg   <= 1'b0;
            page_mask_reg  <= 8'd15;
            write_wait_reg <= 24'd40000;
            fill_wait_reg  <= 24'd120000;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BIT_ORDER:  msb_reg        <= cfg_data[0];
                CFG_TWO_BYTE:   two_byte_reg   <= cfg_data[0];
                CFG_PAGE_MASK:  page_mask_reg  <= cfg_data[7:0];
                CFG_WRITE_WAIT: write_wait_reg <= cfg_data;
                CFG_FILL_WAIT:  fill_wait_reg  <= cfg_data;
                default:        msb_reg        <= msb_reg;
            endcase
        end
    end

    // sequencer state and result word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg <= PH_IDLE; ts_reg <= 3'd0; bi_reg <= 4'd0; sb_reg <= 8'd0;
            ca_reg <= 16'd0; bd_reg <= 16'd0; wc_reg <= 24'd0; ec_reg <= ST_OK;
            ps_reg <= '0; op_reg <= OP_READ; rc_reg <= 16'd0; ba_reg <= 16'd0;
            da_reg <= 8'd0; fv_reg <= 8'd0; wr_reg <= 1'b0;
            scl_reg <= 1'b1; oe_reg <= 1'b1; sdo_reg <= 1'b1;
            ov_reg <= 1'b0; rb_reg <= 8'd0; rv_reg <= 1'b0; busy_reg <= 1'b0;
            done_reg <= 1'b0; st_reg <= ST_OK;
        end
        else
        begin
            if (accept)
            begin
                ph_reg <= ph_next; ts_reg <= ts_next; bi_reg <= bi_next;
                sb_reg <= sb_next; ca_reg <= ca_next; bd_reg <= bd_next;
                wc_reg <= wc_next; ec_reg <= ec_next; ps_reg <= ps_next;
                op_reg <= op_next; rc_reg <= rc_next; ba_reg <= ba_next;
                da_reg <= da_next; fv_reg <= fv_next; wr_reg <= wr_next;
                scl_reg <= scl_next; oe_reg <= oe_next; sdo_reg <= sdo_next;
                rb_reg <= rb_next; rv_reg <= rv_next;
                busy_reg <= (ph_next != PH_IDLE);
                done_reg <= done_next; st_reg <= st_next;
                ov_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = ov_reg;
    assign scl        = scl_reg;
    assign sda_oe     = oe_reg;
    assign sda_out    = sdo_reg;
    assign read_byte  = rb_reg;
    assign read_valid = rv_reg;
    assign busy_res   = busy_reg;
    assign done_res   = done_reg;
    assign status     = st_reg;

    // checks
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> !busy_res)
        else $error("done word while still busy");

    a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && read_valid |-> busy_res && !done_res)
        else $error("read word outside a request");

    a_status_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> done_res)
        else $error("status without done");

    a_idle_bus: assert property (@(posedge clk) disable iff (!rst_n)
        ph_reg == PH_IDLE |-> scl_reg && sdo_reg && oe_reg)
        else $error("bus not released while idle");

endmodule
`default_nettype wire
